// ===== design/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants for the pinhole point projection
// Widths of the camera-space datapath, register map codes and status codes.
// ----------------------------------------------------------------------------
package ppp_pkg;

	// input coordinate width (signed, 12 fraction bits)
	localparam int COORD_WIDTH = 24;
	localparam int ROT_W       = 16;
	localparam int TR_W        = 21;
	localparam int FX_W        = 32;
	localparam int THR_W       = 32;

	// camera coordinate: Q.26, wide enough for three products plus translation
	localparam int PROD_W = COORD_WIDTH + ROT_W;
	localparam int TRS_W  = TR_W + 14;
	localparam int CAM_W  = ((PROD_W > TRS_W) ? PROD_W : TRS_W) + 2;
	localparam int CMP_W  = (CAM_W > THR_W + 10) ? CAM_W : THR_W + 10;

	// focal times coordinate magnitude, split multiply halves
	localparam int NUM_W = FX_W + CAM_W;
	localparam int LO_W  = CAM_W / 2;
	localparam int HI_W  = CAM_W - LO_W;

	// quotient bits produced by the divider; larger quotients clamp
	localparam int QB     = 41;
	localparam int Q_W    = QB + 1;
	localparam int TERM_W = Q_W + 1;
	localparam int SUM_W  = TERM_W + 1;

	// configuration port
	localparam int CFG_AW = 6;
	localparam int CFG_DW = 64;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		REG_FOCAL  = 3'd0,
		REG_CENTER = 3'd1,
		REG_ROT0   = 3'd2,
		REG_ROT1   = 3'd3,
		REG_ROT2   = 3'd4,
		REG_TRANS  = 3'd5,
		REG_THRESH = 3'd6,
		REG_MODE   = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_ERROR   = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [FX_W-1:0] fx;
		logic signed [FX_W-1:0] fy;
		logic signed [FX_W-1:0] cx;
		logic signed [FX_W-1:0] cy;
		logic [2:0][3*ROT_W-1:0] rot;
		logic [3*TR_W-1:0]       tr;
		logic [THR_W-1:0]        thr;
		logic                    inv_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [CAM_W-1:0] x;
		logic signed [CAM_W-1:0] y;
		logic signed [CAM_W-1:0] z;
		logic                    inf;
	} cam_t;

endpackage

// ===== design/ppp_if.sv =====
// ----------------------------------------------------------------------------
// ppp_if: stream channels of the pinhole point projection
// Valid/ready channels for world points in and pixel positions out.
// ----------------------------------------------------------------------------
interface ppp_point_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ppp_pkg::COORD_WIDTH-1:0] point_x;
	logic signed [ppp_pkg::COORD_WIDTH-1:0] point_y;
	logic signed [ppp_pkg::COORD_WIDTH-1:0] point_z;

	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_pixel_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pixel_u;
	logic signed [31:0] pixel_v;
	logic [1:0]         status;

	modport source (output valid, pixel_u, pixel_v, status, input ready);
	modport sink (input valid, pixel_u, pixel_v, status, output ready);
endinterface

// ===== design/ppp_cfg.sv =====
// ----------------------------------------------------------------------------
// ppp_cfg: configuration register file
// APB-style write/read port holding camera pose and intrinsics.
// ----------------------------------------------------------------------------
module ppp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ppp_pkg::CFG_AW-1:0]   paddr,
	input  logic [ppp_pkg::CFG_DW-1:0]   pwdata,
	output logic [ppp_pkg::CFG_DW-1:0]   prdata,
	output logic                         pready,
	output ppp_pkg::cfg_t                cfg
);
	import ppp_pkg::*;

	logic [63:0]          focal_q, center_q;
	logic [3*ROT_W-1:0]   rot0_q, rot1_q, rot2_q;
	logic [3*TR_W-1:0]    trans_q;
	logic [THR_W-1:0]     thr_q;
	logic                 mode_q;
	logic                 wr_en;
	cfg_idx_t             idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = cfg_idx_t'(paddr[CFG_AW-1:3]);

	// write on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q  <= '0;
			center_q <= '0;
			rot0_q   <= '0;
			rot1_q   <= '0;
			rot2_q   <= '0;
			trans_q  <= '0;
			thr_q    <= THR_W'(1);
			mode_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_FOCAL:  focal_q  <= pwdata;
				REG_CENTER: center_q <= pwdata;
				REG_ROT0:   rot0_q   <= pwdata[3*ROT_W-1:0];
				REG_ROT1:   rot1_q   <= pwdata[3*ROT_W-1:0];
				REG_ROT2:   rot2_q   <= pwdata[3*ROT_W-1:0];
				REG_TRANS:  trans_q  <= pwdata[3*TR_W-1:0];
				REG_THRESH: thr_q    <= pwdata[THR_W-1:0];
				REG_MODE:   mode_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_FOCAL:  prdata = focal_q;
			REG_CENTER: prdata = center_q;
			REG_ROT0:   prdata = CFG_DW'(rot0_q);
			REG_ROT1:   prdata = CFG_DW'(rot1_q);
			REG_ROT2:   prdata = CFG_DW'(rot2_q);
			REG_TRANS:  prdata = CFG_DW'(trans_q);
			REG_THRESH: prdata = CFG_DW'(thr_q);
			REG_MODE:   prdata = CFG_DW'(mode_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.fx       = focal_q[63:32];
	assign cfg.fy       = focal_q[31:0];
	assign cfg.cx       = center_q[63:32];
	assign cfg.cy       = center_q[31:0];
	assign cfg.rot      = {rot2_q, rot1_q, rot0_q};
	assign cfg.tr       = trans_q;
	assign cfg.thr      = thr_q;
	assign cfg.inv_mode = mode_q;
endmodule

// ===== design/ppp_front.sv =====
// ----------------------------------------------------------------------------
// ppp_front: world-to-camera transform and depth classification
// Accepts points, computes R*p + t and flags points at infinity.
// ----------------------------------------------------------------------------
module ppp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  ppp_pkg::cfg_t cfg,
	ppp_point_if.sink     points,
	output logic          push,
	output ppp_pkg::cam_t push_data,
	input  logic          can_push
);
	import ppp_pkg::*;

	logic signed [COORD_WIDTH-1:0] pt [3];
	logic signed [PROD_W-1:0]      prod_s1 [3][3];
	logic signed [CAM_W-1:0]       tr_s1 [3];
	logic                          vld_s1;
	logic signed [CAM_W-1:0]       cam_s2 [3];
	logic                          vld_s2;
	logic                          adv;
	logic [CAM_W-1:0]              az;
	logic                          inf;

	assign pt[0] = points.point_x;
	assign pt[1] = points.point_y;
	assign pt[2] = points.point_z;

	// whole front advances unless the last stage is blocked by the queue
	assign adv          = !vld_s2 || can_push;
	assign points.ready = adv;

	// stage 1: nine products and scaled translation
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[i][k] <= $signed(cfg.rot[i][ROT_W*k +: ROT_W]) * pt[k];
				end
				tr_s1[i] <= CAM_W'($signed({cfg.tr[TR_W*i +: TR_W], 14'b0}));
			end
		end
	end

	// stage 2: row sums
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cam_s2[i] <= tr_s1[i] + CAM_W'(prod_s1[i][0]) + CAM_W'(prod_s1[i][1])
					+ CAM_W'(prod_s1[i][2]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= points.valid;
			vld_s2 <= vld_s1;
		end
	end

	// classify depth: zero or below threshold means infinity
	assign az  = cam_s2[2][CAM_W-1] ? CAM_W'(-cam_s2[2]) : CAM_W'(cam_s2[2]);
	assign inf = (cam_s2[2] == '0) || (CMP_W'(az) < CMP_W'({cfg.thr, 10'b0}));

	assign push        = vld_s2 && can_push;
	assign push_data.x = cam_s2[0];
	assign push_data.y = cam_s2[1];
	assign push_data.z = cam_s2[2];
	assign push_data.inf = inf;
endmodule

// ===== design/ppp_queue.sv =====
// ----------------------------------------------------------------------------
// ppp_queue: short queue between front and back
// Small register queue so each side can stall on its own.
// ----------------------------------------------------------------------------
module ppp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ppp_pkg::cam_t push_data,
	output logic          can_push,
	input  logic          take,
	output logic          head_vld,
	output ppp_pkg::cam_t head
);
	import ppp_pkg::*;

	cam_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              pop;

	assign head_vld = cnt_q != '0;
	assign head     = mem_q[rd_q];
	assign pop      = head_vld && take;
	assign can_push = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH)) || pop;

	// store pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== design/ppp_back.sv =====
// ----------------------------------------------------------------------------
// ppp_back: focal scaling, pipelined division and pixel output
// Two lanes (u, v) of multiply, bit-per-stage division, rounding, saturation.
// ----------------------------------------------------------------------------
module ppp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ppp_pkg::cfg_t cfg,
	input  logic          head_vld,
	input  ppp_pkg::cam_t head,
	output logic          take,
	ppp_pixel_if.source   pixels
);
	import ppp_pkg::*;

	logic                       adv;
	logic                       out_vld_q;
	// stage 1
	cam_t                       cam_s1;
	logic                       vld_s1;
	// stage 2: magnitudes
	logic [FX_W-1:0]            fm_s2 [2];
	logic [CAM_W-1:0]           cm_s2 [2];
	logic [CAM_W-1:0]           d_s2;
	logic                       neg_s2 [2];
	logic                       inf_s2, vld_s2;
	// stage 3: partial products
	logic [FX_W+LO_W-1:0]       plo_s3 [2];
	logic [FX_W+HI_W-1:0]       phi_s3 [2];
	logic [CAM_W-1:0]           d_s3;
	logic                       neg_s3 [2];
	logic                       inf_s3, vld_s3;
	// divider stages, index 0 is the loaded numerator
	logic [CAM_W:0]             r_sd [2][QB+1];
	logic [QB-1:0]              q_sd [2][QB+1];
	logic [QB-1:0]              n_sd [2][QB+1];
	logic                       ovf_sd [2][QB+1];
	logic                       neg_sd [2][QB+1];
	logic [CAM_W-1:0]           d_sd [QB+1];
	logic                       inf_sd [QB+1];
	logic                       vld_sd [QB+1];
	// round and clamp
	logic signed [TERM_W-1:0]   term_s5 [2];
	logic                       inf_s5, vld_s5;
	// combinational helpers
	logic signed [FX_W-1:0]     fsel [2];
	logic signed [CAM_W-1:0]    csel [2];
	logic [NUM_W-1:0]           num [2];
	logic [CAM_W:0]             trial [2][QB+1];
	logic                       ge [2][QB+1];
	logic [Q_W-1:0]             qr [2];
	logic [Q_W-1:0]             mag [2];
	logic signed [SUM_W-1:0]    sum [2];
	logic signed [FX_W-1:0]     ctr [2];
	logic signed [31:0]         sat [2];
	logic signed [31:0]         u_q, v_q;
	status_t                    status_q;

	// whole back advances when the output register is free or drains
	assign adv  = !out_vld_q || pixels.ready;
	assign take = adv;

	assign fsel[0] = cfg.fx;
	assign fsel[1] = cfg.fy;
	assign csel[0] = cam_s1.x;
	assign csel[1] = cam_s1.y;
	assign ctr[0]  = cfg.cx;
	assign ctr[1]  = cfg.cy;

	// assemble numerator and run one quotient bit per stage
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			num[l] = NUM_W'({phi_s3[l], {LO_W{1'b0}}}) + NUM_W'(plo_s3[l]);
			trial[l][0] = '0;
			ge[l][0]    = 1'b0;
			for (int j = 1; j <= QB; j++) begin
				trial[l][j] = {r_sd[l][j-1][CAM_W-1:0], n_sd[l][j-1][QB-1]};
				ge[l][j]    = trial[l][j] >= {1'b0, d_sd[j-1]};
			end
		end
	end

	// round half away from zero, clamp, apply sign, add principal point, saturate
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qr[l] = {1'b0, q_sd[l][QB]} +
				Q_W'({r_sd[l][QB], 1'b0} >= {2'b0, d_sd[QB]});
			mag[l] = (ovf_sd[l][QB] || qr[l] > (Q_W'(1) << 40)) ? (Q_W'(1) << 40) : qr[l];
			sum[l] = SUM_W'(ctr[l]) + SUM_W'(term_s5[l]);
			if (sum[l] > SUM_W'(33'sh0_7FFF_FFFF)) begin
				sat[l] = 32'sh7FFF_FFFF;
			end else if (sum[l] < -SUM_W'(33'sh0_8000_0000)) begin
				sat[l] = -32'sh8000_0000;
			end else begin
				sat[l] = sum[l][31:0];
			end
		end
	end

	// datapath registers, all on the shared advance
	always_ff @(posedge clk) begin
		if (adv) begin
			cam_s1 <= head;
			for (int l = 0; l < 2; l++) begin
				fm_s2[l]  <= fsel[l][FX_W-1] ? FX_W'(-fsel[l]) : FX_W'(fsel[l]);
				cm_s2[l]  <= csel[l][CAM_W-1] ? CAM_W'(-csel[l]) : CAM_W'(csel[l]);
				neg_s2[l] <= fsel[l][FX_W-1] ^ csel[l][CAM_W-1] ^ cam_s1.z[CAM_W-1];
				plo_s3[l] <= fm_s2[l] * cm_s2[l][LO_W-1:0];
				phi_s3[l] <= fm_s2[l] * cm_s2[l][CAM_W-1:LO_W];
				neg_s3[l] <= neg_s2[l];
				r_sd[l][0]   <= (CAM_W+1)'(num[l][NUM_W-1:QB]);
				n_sd[l][0]   <= num[l][QB-1:0];
				q_sd[l][0]   <= '0;
				ovf_sd[l][0] <= (CMP_W+1)'(num[l][NUM_W-1:QB]) >= (CMP_W+1)'(d_s3);
				neg_sd[l][0] <= neg_s3[l];
				for (int j = 1; j <= QB; j++) begin
					r_sd[l][j]   <= ge[l][j] ? trial[l][j] - {1'b0, d_sd[j-1]} : trial[l][j];
					q_sd[l][j]   <= {q_sd[l][j-1][QB-2:0], ge[l][j]};
					n_sd[l][j]   <= {n_sd[l][j-1][QB-2:0], 1'b0};
					ovf_sd[l][j] <= ovf_sd[l][j-1];
					neg_sd[l][j] <= neg_sd[l][j-1];
				end
				term_s5[l] <= neg_sd[l][QB] ? -TERM_W'(mag[l]) : TERM_W'(mag[l]);
			end
			d_s2   <= cam_s1.z[CAM_W-1] ? CAM_W'(-cam_s1.z) : CAM_W'(cam_s1.z);
			inf_s2 <= cam_s1.inf;
			d_s3   <= d_s2;
			inf_s3 <= inf_s2;
			d_sd[0]   <= d_s3;
			inf_sd[0] <= inf_s3;
			for (int j = 1; j <= QB; j++) begin
				d_sd[j]   <= d_sd[j-1];
				inf_sd[j] <= inf_sd[j-1];
			end
			inf_s5 <= inf_sd[QB];
			u_q <= inf_s5 ? '0 : sat[0];
			v_q <= inf_s5 ? '0 : sat[1];
			status_q <= !inf_s5 ? ST_OK : (cfg.inv_mode ? ST_INVALID : ST_ERROR);
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int j = 0; j <= QB; j++) begin
				vld_sd[j] <= 1'b0;
			end
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= head_vld;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_sd[0] <= vld_s3;
			for (int j = 1; j <= QB; j++) begin
				vld_sd[j] <= vld_sd[j-1];
			end
			vld_s5    <= vld_sd[QB];
			out_vld_q <= vld_s5;
		end
	end

	assign pixels.valid   = out_vld_q;
	assign pixels.pixel_u = u_q;
	assign pixels.pixel_v = v_q;
	assign pixels.status  = status_q;
endmodule

// ===== design/pinhole_point_projection.sv =====
// Throughput: one point per cycle while the output is not stalled; the 41-stage divider holds one item per stage.
// A stalled output freezes the back pipeline; the four-entry queue lets the front keep going.
// Reset (arst_n low) clears all valid flags and the queue, and loads register defaults.
// ----------------------------------------------------------------------------
// pinhole_point_projection: world point to pixel projection
// Front transforms points into camera space, back scales and divides by depth.
// ----------------------------------------------------------------------------
module pinhole_point_projection (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ppp_pkg::CFG_AW-1:0] paddr,
	input  logic [ppp_pkg::CFG_DW-1:0] pwdata,
	output logic [ppp_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	ppp_point_if.sink                  points,
	ppp_pixel_if.source                pixels
);
	import ppp_pkg::*;

	cfg_t cfg;
	logic push, can_push, take, head_vld;
	cam_t push_data, head;

	ppp_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	ppp_front u_front (
		.clk, .arst_n, .cfg, .points, .push, .push_data, .can_push
	);

	ppp_queue u_queue (
		.clk, .arst_n, .push, .push_data, .can_push, .take, .head_vld, .head
	);

	ppp_back u_back (
		.clk, .arst_n, .cfg, .head_vld, .head, .take, .pixels
	);
endmodule

// ===== design/ppp_checker.sv =====
// ----------------------------------------------------------------------------
// ppp_checker: port-level checks of the pinhole point projection
// Output status and payload rules, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ppp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_u,
	input logic [31:0] out_v,
	input logic [1:0]  out_status
);
	import ppp_pkg::*;

	// points at infinity carry zero coordinates
	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_OK |-> out_u == '0 && out_v == '0)
		else $error("infinity result with nonzero pixel");

	// status code is one of the three defined values
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status == ST_OK || out_status == ST_INVALID
			|| out_status == ST_ERROR)
		else $error("undefined status code");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_u) && $stable(out_v)
			&& $stable(out_status))
		else $error("stalled result changed");

	// configuration port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");
endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pready     (pready),
	.out_valid  (pixels.valid),
	.out_ready  (pixels.ready),
	.out_u      (pixels.pixel_u),
	.out_v      (pixels.pixel_v),
	.out_status (pixels.status)
);
